// ----- hw/rtl/rtu_pkg.sv -----
// shared widths, register indexes, reset values and arithmetic helpers
package rtu_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;
  // 16 x 9 signed product is 25 bits, three of them summed need 27
  localparam int unsigned SUM_W   = 27;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SH_W    = SUM_W - FRAC_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_COEFFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CB_COEFFS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_COEFFS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_OFFSET = 3'd4;

  // reset values of the configuration registers
  localparam logic [ROW_W-1:0]  LUMA_COEFFS_RST   = 48'h0019_0081_0042;
  localparam logic [ROW_W-1:0]  CB_COEFFS_RST     = 48'h0070_FFB6_FFDA;
  localparam logic [ROW_W-1:0]  CR_COEFFS_RST     = 48'hFFEE_FFA2_0070;
  localparam logic [COEF_W-1:0] LUMA_OFFSET_RST   = 16'd16;
  localparam logic [COEF_W-1:0] CHROMA_OFFSET_RST = 16'd128;

  // rounded-up average of two components
  function automatic logic [PIX_W-1:0] avg_up(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
    return s[PIX_W:1];
  endfunction

  // signed weighted sum of r, g, b with one coefficient row
  function automatic logic signed [SUM_W-1:0] dot3(input logic [ROW_W-1:0] row,
                                                   input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b);
    logic signed [COEF_W+PIX_W:0] pr;
    logic signed [COEF_W+PIX_W:0] pg;
    logic signed [COEF_W+PIX_W:0] pb;
    pr = $signed(row[COEF_W-1:0])        * $signed({1'b0, r});
    pg = $signed(row[2*COEF_W-1:COEF_W]) * $signed({1'b0, g});
    pb = $signed(row[ROW_W-1:2*COEF_W])  * $signed({1'b0, b});
    return SUM_W'(pr) + SUM_W'(pg) + SUM_W'(pb);
  endfunction

  // floor shift, saturate, add offset with saturation, clamp to a byte
  function automatic logic [PIX_W-1:0] finish(input logic signed [SUM_W-1:0] s,
                                              input logic signed [COEF_W-1:0] off);
    logic signed [SH_W-1:0]   sh;
    logic signed [COEF_W-1:0] v;
    logic signed [COEF_W:0]   t;
    logic signed [COEF_W-1:0] w;
    sh = s[SUM_W-1:FRAC_BITS];
    if (sh > 32767) begin
      v = 16'sh7FFF;
    end else if (sh < -32768) begin
      v = 16'sh8000;
    end else begin
      v = sh[COEF_W-1:0];
    end
    t = (COEF_W+1)'(v) + (COEF_W+1)'(off);
    if (t > 32767) begin
      w = 16'sh7FFF;
    end else if (t < -32768) begin
      w = 16'sh8000;
    end else begin
      w = t[COEF_W-1:0];
    end
    if (w < 0) begin
      return '0;
    end else if (w > 255) begin
      return '1;
    end else begin
      return w[PIX_W-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/rtu_pix_if.sv -----
// pixel pair channel: valid, ready and two rgb pixels
interface rtu_pix_if;
  import rtu_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_first;
  logic [PIX_W-1:0] green_first;
  logic [PIX_W-1:0] blue_first;
  logic [PIX_W-1:0] red_second;
  logic [PIX_W-1:0] green_second;
  logic [PIX_W-1:0] blue_second;
  logic             last_pair;

  modport source (output valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, last_pair,
                  input ready);
  modport sink   (input valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, last_pair,
                  output ready);
endinterface

// ----- hw/rtl/rtu_uyvy_if.sv -----
// uyvy macropixel channel: valid, ready and the four samples
interface rtu_uyvy_if;
  import rtu_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chroma_u;
  logic [PIX_W-1:0] luma_first;
  logic [PIX_W-1:0] chroma_v;
  logic [PIX_W-1:0] luma_second;
  logic             last_out;

  modport source (output valid, chroma_u, luma_first, chroma_v, luma_second, last_out,
                  input ready);
  modport sink   (input valid, chroma_u, luma_first, chroma_v, luma_second, last_out,
                  output ready);
endinterface

// ----- hw/rtl/rtu_cfg_if.sv -----
// configuration write channel: valid, ready, register index and data
interface rtu_cfg_if;
  import rtu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rgba_to_uyvy_converter.sv -----
// rgb pixel pair to uyvy macropixel converter, three register stages
//
// One pixel pair is taken per clock unless the output stalls; each UYVY
// macropixel passes an input register (forming the pair's rounded-up
// r, g, b averages), a register holding the four signed weighted sums, and
// the output register after shift, saturation, offset and clamping. The
// whole pipeline advances together and stalls only while a finished
// macropixel is held at the output, so the throughput is one transaction
// per cycle when the sink keeps ready high. Configuration writes are taken
// at any time and should be made while no transaction is in flight.
module rgba_to_uyvy_converter (
  input  logic       clk,
  input  logic       rst,
  rtu_pix_if.sink    pix,
  rtu_uyvy_if.source uyvy,
  rtu_cfg_if.sink    cfg
);
  import rtu_pkg::*;

  // configuration registers
  logic [ROW_W-1:0]         luma_coeffs;
  logic [ROW_W-1:0]         cb_coeffs;
  logic [ROW_W-1:0]         cr_coeffs;
  logic signed [COEF_W-1:0] luma_offset;
  logic signed [COEF_W-1:0] chroma_offset;

  // input stage
  logic             v_a;
  logic [PIX_W-1:0] r0_a, g0_a, b0_a, r1_a, g1_a, b1_a;
  logic [PIX_W-1:0] ra_a, ga_a, ba_a;
  logic             last_a;

  // sum stage
  logic                    v_b;
  logic signed [SUM_W-1:0] sum_u_b, sum_y0_b, sum_v_b, sum_y1_b;
  logic                    last_b;

  // output stage
  logic             v_c;
  logic [PIX_W-1:0] u_c, y0_c, vv_c, y1_c;
  logic             last_c;

  logic adv;

  assign adv       = !v_c || uyvy.ready;
  assign pix.ready = adv;
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_coeffs   <= LUMA_COEFFS_RST;
      cb_coeffs     <= CB_COEFFS_RST;
      cr_coeffs     <= CR_COEFFS_RST;
      luma_offset   <= LUMA_OFFSET_RST;
      chroma_offset <= CHROMA_OFFSET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LUMA_COEFFS:   luma_coeffs   <= cfg.data;
        CFG_CB_COEFFS:     cb_coeffs     <= cfg.data;
        CFG_CR_COEFFS:     cr_coeffs     <= cfg.data;
        CFG_LUMA_OFFSET:   luma_offset   <= cfg.data[COEF_W-1:0];
        CFG_CHROMA_OFFSET: chroma_offset <= cfg.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else if (adv) begin
      v_a <= pix.valid;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  // input register with pair averages
  always_ff @(posedge clk) begin
    if (adv) begin
      r0_a   <= pix.red_first;
      g0_a   <= pix.green_first;
      b0_a   <= pix.blue_first;
      r1_a   <= pix.red_second;
      g1_a   <= pix.green_second;
      b1_a   <= pix.blue_second;
      ra_a   <= avg_up(pix.red_first,   pix.red_second);
      ga_a   <= avg_up(pix.green_first, pix.green_second);
      ba_a   <= avg_up(pix.blue_first,  pix.blue_second);
      last_a <= pix.last_pair;
    end
  end

  // weighted sums
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_u_b  <= dot3(cb_coeffs,   ra_a, ga_a, ba_a);
      sum_y0_b <= dot3(luma_coeffs, r0_a, g0_a, b0_a);
      sum_v_b  <= dot3(cr_coeffs,   ra_a, ga_a, ba_a);
      sum_y1_b <= dot3(luma_coeffs, r1_a, g1_a, b1_a);
      last_b   <= last_a;
    end
  end

  // shift, saturate, offset and clamp into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      u_c    <= finish(sum_u_b,  chroma_offset);
      y0_c   <= finish(sum_y0_b, luma_offset);
      vv_c   <= finish(sum_v_b,  chroma_offset);
      y1_c   <= finish(sum_y1_b, luma_offset);
      last_c <= last_b;
    end
  end

  assign uyvy.valid       = v_c;
  assign uyvy.chroma_u    = u_c;
  assign uyvy.luma_first  = y0_c;
  assign uyvy.chroma_v    = vv_c;
  assign uyvy.luma_second = y1_c;
  assign uyvy.last_out    = last_c;

`ifndef SYNTHESIS
  // an empty pipeline cannot present a transaction on the next cycle
  a_empty_pipe: assert property (@(posedge clk) disable iff (rst)
    (!v_a && !v_b && !v_c) |=> !uyvy.valid)
    else $error("output valid from an empty pipeline");

  // a transaction taken at the input is in the input stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> v_a)
    else $error("accepted transaction lost at the input stage");

  // a luma offset write takes effect on the next cycle
  a_luma_off_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index == CFG_LUMA_OFFSET)
      |=> luma_offset == $past(cfg.data[COEF_W-1:0]))
    else $error("luma offset write not applied");

  // while the output is stalled no stage moves
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (uyvy.valid && !uyvy.ready) |=> ($stable(v_a) && $stable(v_b) && $stable(sum_y0_b)))
    else $error("pipeline moved during an output stall");
`endif

endmodule
